// ===== hdl/alignment_flag_stat_counters_top_macros.svh =====
// Assertion macros for the alignment flag statistics counters.
// Used by alignment_flag_stat_counters_top; expects clk and rst_n in scope.
`ifndef ALIGNMENT_FLAG_STAT_COUNTERS_TOP_MACROS_SVH
`define ALIGNMENT_FLAG_STAT_COUNTERS_TOP_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define AFSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define AFSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/afsc_pkg.sv =====
// Package for the alignment flag statistics counters.
// Types, flag positions, counter codes and register indexes; no dependencies.
package afsc_pkg;

  localparam int COUNTER_WIDTH_DEF = 64;
  localparam int VALUE_W           = 64;
  localparam int NUM_KINDS         = 14;
  localparam int NUM_CLASSES       = 2;
  localparam int NUM_SLOTS         = NUM_KINDS * NUM_CLASSES;
  localparam int SLOT_W            = $clog2(NUM_SLOTS);
  localparam int CFG_INDEX_W       = 1;
  localparam int CFG_DATA_W        = 8;

  // Flag word bit positions.
  localparam int F_PAIRED = 0;
  localparam int F_PROPER = 1;
  localparam int F_UNMAP  = 2;
  localparam int F_MUNMAP = 3;
  localparam int F_READ1  = 6;
  localparam int F_READ2  = 7;
  localparam int F_QCFAIL = 9;
  localparam int F_DUP    = 10;

  localparam logic MODE_COUNT = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_GOOD_QUAL = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_XREF_QUAL = 1'b1;

  localparam logic [7:0] GOOD_QUAL_RST = 8'd30;
  localparam logic [7:0] XREF_QUAL_RST = 8'd5;

  typedef enum logic [3:0] {
    K_TOTAL, K_PAIRED, K_PROPER, K_READ1, K_READ2, K_SINGLETON,
    K_BOTH_MAPPED, K_DIFF_REF, K_DIFF_REF_HIGH, K_UNPAIRED_MAPPED,
    K_UNPAIRED_GOOD, K_MAPPED, K_MAPPED_GOOD, K_DUP
  } kind_t;

  typedef struct packed {
    logic               mode;
    logic [11:0]        flag_bits;
    logic signed [31:0] ref_index;
    logic signed [31:0] mate_ref_index;
    logic [7:0]         mapping_quality;
    logic [3:0]         counter_select;
    logic               class_select;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] counter_value;
  } out_item_t;

endpackage

// ===== hdl/afsc_if.sv =====
// Valid/ready channel interfaces for the alignment flag statistics counters.
// Depends on afsc_pkg for the payload types.
interface afsc_in_if;
  import afsc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface afsc_out_if;
  import afsc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/alignment_flag_stat_counters_top.sv =====
// Channel   | Dir | Payload                                   | Flow
// in_ch     | in  | mode, flags, ref ids, quality, selects    | valid/ready
// out_ch    | out | counter_value (one per read transaction)  | valid/ready
// cfg       | in  | write enable, index, 8-bit data           | write only
// One transaction per cycle sustained unless a read stalls at the output: an input register
// feeds the flag decode and all 28 saturating counters update in parallel the next cycle.
// A read transaction passes the input register, then the output register, onto out_ch.
// Synchronous active-low reset clears all counters and loads the thresholds.
// Only a read waiting behind a stalled output register blocks the input.
//
// Alignment flag statistics counters, top level.
// Depends on afsc_pkg, afsc_if and alignment_flag_stat_counters_top_macros.svh.
`include "alignment_flag_stat_counters_top_macros.svh"

module alignment_flag_stat_counters_top #(
  parameter int COUNTER_WIDTH = afsc_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  afsc_in_if.sink                              in_ch,
  afsc_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [afsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [afsc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import afsc_pkg::*;

  localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

  logic [7:0]               good_qual_r;
  logic [7:0]               xref_qual_r;
  logic                     s1_valid_r, s1_valid_nxt;
  in_item_t                 s1_item_r;
  logic                     s1_advance;
  logic                     in_accept;
  logic                     out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]       out_value_r, out_value_nxt;
  logic [COUNTER_WIDTH-1:0] cnt_r [NUM_SLOTS];
  logic [NUM_KINDS-1:0]     evt;
  logic                     s1_count;
  logic                     s1_read;
  logic [SLOT_W-1:0]        rd_slot;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      good_qual_r <= GOOD_QUAL_RST;
      xref_qual_r <= XREF_QUAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GOOD_QUAL: good_qual_r <= cfg_wdata;
        REG_XREF_QUAL: xref_qual_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Count transactions always leave stage 1; reads need room in the output register.
  assign s1_count   = s1_valid_r && (s1_item_r.mode == MODE_COUNT);
  assign s1_read    = s1_valid_r && (s1_item_r.mode == MODE_READ);
  assign s1_advance = s1_count || (s1_read && (!out_valid_r || out_ch.ready));
  assign in_ch.ready = !s1_valid_r || s1_advance;
  assign in_accept  = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_ch.data;
    end
  end

  // Flag decode into one event bit per counter kind.
  always_comb begin
    logic paired, mapped, mate_mapped, good, both, diff, unp;
    paired      = s1_item_r.flag_bits[F_PAIRED];
    mapped      = !s1_item_r.flag_bits[F_UNMAP];
    mate_mapped = !s1_item_r.flag_bits[F_MUNMAP];
    good        = s1_item_r.mapping_quality >= good_qual_r;
    both        = paired && mapped && mate_mapped;
    diff        = both && (s1_item_r.ref_index != s1_item_r.mate_ref_index);
    unp         = !paired && mapped;
    evt                    = '0;
    evt[K_TOTAL]           = 1'b1;
    evt[K_PAIRED]          = paired;
    evt[K_PROPER]          = paired && s1_item_r.flag_bits[F_PROPER];
    evt[K_READ1]           = paired && s1_item_r.flag_bits[F_READ1];
    evt[K_READ2]           = paired && s1_item_r.flag_bits[F_READ2];
    evt[K_SINGLETON]       = paired && mapped && !mate_mapped;
    evt[K_BOTH_MAPPED]     = both;
    evt[K_DIFF_REF]        = diff;
    evt[K_DIFF_REF_HIGH]   = diff && (s1_item_r.mapping_quality >= xref_qual_r);
    evt[K_UNPAIRED_MAPPED] = unp;
    evt[K_UNPAIRED_GOOD]   = unp && good;
    evt[K_MAPPED]          = mapped;
    evt[K_MAPPED_GOOD]     = mapped && good;
    evt[K_DUP]             = s1_item_r.flag_bits[F_DUP];
  end

  // One saturating counter per class and kind; slot = class * NUM_KINDS + kind.
  for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_cnt
    localparam int  KIND = s % NUM_KINDS;
    localparam logic CLS = (s / NUM_KINDS) != 0;
    logic bump;
    assign bump = s1_count && (s1_item_r.flag_bits[F_QCFAIL] == CLS) && evt[KIND]
                  && (cnt_r[s] != CNT_MAX);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cnt_r[s] <= '0;
      end else if (bump) begin
        cnt_r[s] <= cnt_r[s] + 1'b1;
      end
    end
  end

  assign rd_slot = s1_item_r.class_select
                   ? SLOT_W'(s1_item_r.counter_select) + SLOT_W'(NUM_KINDS)
                   : SLOT_W'(s1_item_r.counter_select);

  // Output register; a read whose selector is out of range returns zero.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    if (s1_read && s1_advance) begin
      out_valid_nxt = 1'b1;
      if (s1_item_r.counter_select < 4'(NUM_KINDS)) begin
        out_value_nxt = VALUE_W'(cnt_r[rd_slot]);
      end else begin
        out_value_nxt = '0;
      end
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.data.counter_value = out_value_r;

  `AFSC_ASSERT_NEXT(a_read_reaches_out, s1_read && s1_advance, out_valid_r, "read transaction did not reach the output register")
  `AFSC_ASSERT_NEXT(a_total_bumps, s1_count && !s1_item_r.flag_bits[F_QCFAIL] && (cnt_r[K_TOTAL] != CNT_MAX), cnt_r[K_TOTAL] == $past(cnt_r[K_TOTAL]) + 1'b1, "QC-passed total did not advance on a count transaction")
  `AFSC_ASSERT_ALWAYS(a_paired_le_total, cnt_r[K_PAIRED] <= cnt_r[K_TOTAL], "paired count exceeds total count")
  `AFSC_ASSERT_ALWAYS(a_mapped_good_le_mapped, cnt_r[K_MAPPED_GOOD] <= cnt_r[K_MAPPED], "good-quality mapped count exceeds mapped count")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for alignment_flag_stat_counters_top: count and read transactions with random
// handshake gaps, checked against a predictor of the 28 saturating counters.
// Depends on afsc_pkg, afsc_if and the block; built with 16-bit counters, read zero-extended.
module tb_top;
  import afsc_pkg::*;

  localparam int CNT_W = 16;
  localparam logic [63:0] CNT_MAX = {64{1'b1}} >> (64 - CNT_W);
  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASES = 6;
  localparam int RAND_PER_PHASE = 243;
  localparam int OPENING_ROWS = 25;
  localparam logic [3:0] SEL_OFF_END = 4'hF;

  localparam logic [11:0] FL_PAIRED = 12'b1 << F_PAIRED;
  localparam logic [11:0] FL_PROPER = 12'b1 << F_PROPER;
  localparam logic [11:0] FL_UNMAP  = 12'b1 << F_UNMAP;
  localparam logic [11:0] FL_MUNMAP = 12'b1 << F_MUNMAP;
  localparam logic [11:0] FL_READ1  = 12'b1 << F_READ1;
  localparam logic [11:0] FL_READ2  = 12'b1 << F_READ2;
  localparam logic [11:0] FL_QCFAIL = 12'b1 << F_QCFAIL;
  localparam logic [11:0] FL_DUP    = 12'b1 << F_DUP;
  localparam logic [11:0] FL_KNOWN  = FL_PAIRED | FL_PROPER | FL_UNMAP | FL_MUNMAP |
                                      FL_READ1 | FL_READ2 | FL_QCFAIL | FL_DUP;

  typedef struct {
    logic        mode;
    logic [11:0] flags;
    logic [31:0] ref_id;
    logic [31:0] mate_id;
    logic [7:0]  qual;
    logic [3:0]  sel;
    logic        cls;
    logic        fixed;
    logic [63:0] value;
  } opening_row_t;

  // Rows with fixed set carry a value that is known without the predictor.
  opening_row_t opening_rows [OPENING_ROWS] = '{
    '{MODE_READ,  12'h000, 32'd0, 32'd0, 8'd0, K_TOTAL, 1'b0, 1'b1, 64'd0},
    '{MODE_READ,  12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, K_DUP, 1'b1, 1'b1, 64'd0},
    '{MODE_READ,  12'h000, 32'd0, 32'd0, 8'd0, SEL_OFF_END, 1'b0, 1'b1, 64'd0},
    '{MODE_COUNT, 12'h000, 32'd0, 32'd0, 8'd0, K_TOTAL, 1'b0, 1'b0, 64'd0},
    '{MODE_COUNT, 12'hFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 8'd255, K_TOTAL, 1'b0, 1'b0, 64'd0},
    '{MODE_COUNT, FL_PAIRED | FL_PROPER | FL_READ1 | FL_READ2, 32'd5, 32'd5, 8'd30,
      K_TOTAL, 1'b0, 1'b0, 64'd0},
    '{MODE_COUNT, FL_PAIRED | FL_READ1, 32'd3, 32'hFFFF_FFFF, 8'd5, K_TOTAL, 1'b0, 1'b0, 64'd0},
    '{MODE_COUNT, FL_PAIRED | FL_READ2, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 8'd4,
      K_TOTAL, 1'b0, 1'b0, 64'd0},
    '{MODE_COUNT, FL_PAIRED | FL_MUNMAP, 32'd1, 32'd1, 8'd29, K_TOTAL, 1'b0, 1'b0, 64'd0},
    '{MODE_COUNT, FL_UNMAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, K_TOTAL, 1'b0, 1'b0, 64'd0},
    '{MODE_COUNT, FL_DUP, 32'd0, 32'd0, 8'd30, K_TOTAL, 1'b0, 1'b0, 64'd0},
    '{MODE_COUNT, FL_QCFAIL, 32'd2, 32'd2, 8'd255, K_TOTAL, 1'b0, 1'b0, 64'd0},
    '{MODE_COUNT, FL_PAIRED | FL_UNMAP, 32'hFFFF_FFFF, 32'd4, 8'd0, K_TOTAL, 1'b0, 1'b0, 64'd0},
    '{MODE_READ, 12'h000, 32'd0, 32'd0, 8'd0, K_PAIRED, 1'b0, 1'b0, 64'd0},
    '{MODE_READ, 12'h000, 32'd0, 32'd0, 8'd0, K_PROPER, 1'b0, 1'b0, 64'd0},
    '{MODE_READ, 12'h000, 32'd0, 32'd0, 8'd0, K_READ1, 1'b0, 1'b0, 64'd0},
    '{MODE_READ, 12'h000, 32'd0, 32'd0, 8'd0, K_SINGLETON, 1'b0, 1'b0, 64'd0},
    '{MODE_READ, 12'h000, 32'd0, 32'd0, 8'd0, K_DIFF_REF, 1'b0, 1'b0, 64'd0},
    '{MODE_READ, 12'h000, 32'd0, 32'd0, 8'd0, K_DIFF_REF_HIGH, 1'b0, 1'b0, 64'd0},
    '{MODE_READ, 12'h000, 32'd0, 32'd0, 8'd0, K_UNPAIRED_GOOD, 1'b0, 1'b0, 64'd0},
    '{MODE_READ, 12'h000, 32'd0, 32'd0, 8'd0, K_MAPPED_GOOD, 1'b0, 1'b0, 64'd0},
    '{MODE_READ, 12'h000, 32'd0, 32'd0, 8'd0, K_TOTAL, 1'b1, 1'b0, 64'd0},
    '{MODE_READ, 12'h000, 32'd0, 32'd0, 8'd0, K_READ2, 1'b1, 1'b0, 64'd0},
    '{MODE_READ, 12'h000, 32'd0, 32'd0, 8'd0, K_MAPPED, 1'b1, 1'b0, 64'd0},
    '{MODE_READ, 12'h000, 32'd0, 32'd0, 8'd0, K_DUP, 1'b1, 1'b0, 64'd0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  afsc_in_if  in_if ();
  afsc_out_if out_if ();

  alignment_flag_stat_counters_top #(.COUNTER_WIDTH(CNT_W)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  logic [63:0] event_tally [NUM_SLOTS];
  logic [7:0]  good_thr;
  logic [7:0]  xref_thr;
  logic [63:0] awaited_values [$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  bit          calm = 1'b0;
  bit          stream_on = 1'b0;

  function automatic void bump(input int base, input kind_t kind);
    int slot;
    slot = base + int'(kind);
    if (event_tally[slot] < CNT_MAX) event_tally[slot]++;
  endfunction

  function automatic void tally_record(input in_item_t rec);
    int   base;
    logic mapped;
    logic mate_mapped;
    logic good;
    base        = rec.flag_bits[F_QCFAIL] ? NUM_KINDS : 0;
    mapped      = !rec.flag_bits[F_UNMAP];
    mate_mapped = !rec.flag_bits[F_MUNMAP];
    good        = rec.mapping_quality >= good_thr;
    bump(base, K_TOTAL);
    if (rec.flag_bits[F_PAIRED]) begin
      bump(base, K_PAIRED);
      if (rec.flag_bits[F_PROPER]) bump(base, K_PROPER);
      if (rec.flag_bits[F_READ1]) bump(base, K_READ1);
      if (rec.flag_bits[F_READ2]) bump(base, K_READ2);
      if (mapped && !mate_mapped) bump(base, K_SINGLETON);
      if (mapped && mate_mapped) begin
        bump(base, K_BOTH_MAPPED);
        // Indexes are compared as raw patterns, so -1 against a real index counts too.
        if (rec.ref_index != rec.mate_ref_index) begin
          bump(base, K_DIFF_REF);
          if (rec.mapping_quality >= xref_thr) bump(base, K_DIFF_REF_HIGH);
        end
      end
    end else if (mapped) begin
      bump(base, K_UNPAIRED_MAPPED);
      if (good) bump(base, K_UNPAIRED_GOOD);
    end
    if (mapped) begin
      bump(base, K_MAPPED);
      if (good) bump(base, K_MAPPED_GOOD);
    end
    if (rec.flag_bits[F_DUP]) bump(base, K_DUP);
  endfunction

  function automatic logic [63:0] tally_lookup(input logic [3:0] sel, input logic cls);
    if (int'(sel) >= NUM_KINDS) return 64'd0;
    return event_tally[int'(cls) * NUM_KINDS + int'(sel)];
  endfunction

  function automatic int pick_gap();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic logic [31:0] pick_ref();
    case ($urandom_range(0, 4))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'($urandom_range(0, 3));
      default: return $urandom & 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic logic [7:0] pick_qual();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 255));
      1:       return good_thr + 8'($urandom_range(0, 2)) - 8'd1;
      2:       return xref_thr + 8'($urandom_range(0, 2)) - 8'd1;
      default: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    endcase
  endfunction

  function automatic in_item_t random_txn();
    in_item_t txn;
    txn.mode            = ($urandom_range(0, 3) == 0) ? MODE_READ : MODE_COUNT;
    txn.flag_bits       = 12'($urandom_range(0, 4095));
    // About half the records keep to the defined flag bits, and pairs are the common case.
    if ($urandom_range(0, 1)) begin
      txn.flag_bits = txn.flag_bits & FL_KNOWN;
      if ($urandom_range(0, 3) != 0) txn.flag_bits = txn.flag_bits | FL_PAIRED;
    end
    txn.ref_index       = pick_ref();
    txn.mate_ref_index  = $urandom_range(0, 1) ? txn.ref_index : pick_ref();
    txn.mapping_quality = pick_qual();
    txn.counter_select  = 4'($urandom_range(0, 15));
    txn.class_select    = 1'($urandom_range(0, 1));
    return txn;
  endfunction

  // Offers one transaction and books its effect at the edge where it is accepted.
  task automatic send_txn(input in_item_t txn, input logic fixed, input logic [63:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      if (stream_on) in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= txn;
    stream_on = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    if (txn.mode == MODE_COUNT) tally_record(txn);
    else if (fixed) awaited_values.push_back(value);
    else awaited_values.push_back(tally_lookup(txn.counter_select, txn.class_select));
  endtask

  task automatic stop_stream();
    if (stream_on) in_if.valid <= 1'b0;
    stream_on = 1'b0;
  endtask

  // Count records leave no result behind, so give the pipeline time after the last read.
  task automatic settle();
    stop_stream();
    while (awaited_values.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_we    <= 1'b1;
    @(posedge clk);
    if (idx == REG_GOOD_QUAL) good_thr = val;
    else if (idx == REG_XREF_QUAL) xref_thr = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t row_txn(input opening_row_t row);
    in_item_t txn;
    txn.mode            = row.mode;
    txn.flag_bits       = row.flags;
    txn.ref_index       = row.ref_id;
    txn.mate_ref_index  = row.mate_id;
    txn.mapping_quality = row.qual;
    txn.counter_select  = row.sel;
    txn.class_select    = row.cls;
    return txn;
  endfunction

  // Result side: random stalls, each result checked against the oldest awaited value.
  initial begin
    int stall;
    logic [63:0] want;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      if (awaited_values.size() == 0) begin
        $display("%0t: result %h arrived with nothing expected", $time,
                 out_if.data.counter_value);
        mismatch_count++;
      end else begin
        want = awaited_values.pop_front();
        if (out_if.data.counter_value !== want) begin
          $display("%0t: counter_value mismatch, expected %h, actual %h", $time, want,
                   out_if.data.counter_value);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    in_item_t txn;
    logic [7:0] good_val;
    logic [7:0] xref_val;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_GOOD_QUAL;
    cfg_wdata <= 8'd0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    foreach (event_tally[i]) event_tally[i] = 64'd0;
    good_thr = GOOD_QUAL_RST;
    xref_thr = XREF_QUAL_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_rows[i])
      send_txn(row_txn(opening_rows[i]), opening_rows[i].fixed, opening_rows[i].value);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        case (ph)
          1: begin good_val = 8'd0;   xref_val = 8'd0;   end
          2: begin good_val = 8'd255; xref_val = 8'd255; end
          3: begin good_val = 8'd1;   xref_val = 8'd254; end
          default: begin
            good_val = 8'($urandom_range(0, 255));
            xref_val = 8'($urandom_range(0, 255));
          end
        endcase
        settle();
        write_reg(REG_GOOD_QUAL, good_val);
        write_reg(REG_XREF_QUAL, xref_val);
      end
      // One phase runs with no idling on either side.
      calm = (ph == 3);
      repeat (RAND_PER_PHASE) send_txn(random_txn(), 1'b0, 64'd0);
    end

    // Read back every counter of both classes.
    calm = 1'b0;
    for (int c = 0; c < NUM_CLASSES; c++)
      for (int k = 0; k < NUM_KINDS; k++) begin
        txn = '0;
        txn.mode           = MODE_READ;
        txn.counter_select = 4'(k);
        txn.class_select   = 1'(c);
        send_txn(txn, 1'b0, 64'd0);
      end
    repeat (40) send_txn(random_txn(), 1'b0, 64'd0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
